### rtl/core/u8cp_pkg.sv
// ----------------------------------------------------------------------------
// u8cp_pkg
// Shared types, codes and the CP1252 back-mapping table for the UTF-8 to
// single-byte transcoder.
// ----------------------------------------------------------------------------
package u8cp_pkg;

  localparam int unsigned OffsetBitsDef = 16;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned CodeW    = 21;
  localparam int unsigned ErrOffW  = 16;
  localparam int unsigned OutDataW = 48;  // 8 + 16 + 21 = 45, padded to bytes
  localparam int unsigned StatusW  = 2;

  // Result status codes
  localparam logic [StatusW-1:0] StByte    = 2'd0;
  localparam logic [StatusW-1:0] StInvalid = 2'd1;
  localparam logic [StatusW-1:0] StUnrep   = 2'd2;

  // Allowed range of the next continuation byte
  localparam logic [2:0] ClsAny  = 3'd0;  // 80-BF
  localparam logic [2:0] ClsE0   = 3'd1;  // A0-BF
  localparam logic [2:0] ClsEd   = 3'd2;  // 80-9F
  localparam logic [2:0] ClsF0   = 3'd3;  // 90-BF
  localparam logic [2:0] ClsF4   = 3'd4;  // 80-8F

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } map_t;

  // Windows-1252 back-mapping of the 27 high code points
  function automatic map_t cp1252_lookup(input logic [CodeW-1:0] cp);
    map_t r;
    r.hit  = 1'b1;
    r.code = 8'h00;
    case (cp)
      21'h0152: r.code = 8'h8C;
      21'h0153: r.code = 8'h9C;
      21'h0160: r.code = 8'h8A;
      21'h0161: r.code = 8'h9A;
      21'h0178: r.code = 8'h9F;
      21'h017D: r.code = 8'h8E;
      21'h017E: r.code = 8'h9E;
      21'h0192: r.code = 8'h83;
      21'h02C6: r.code = 8'h88;
      21'h02DC: r.code = 8'h98;
      21'h2013: r.code = 8'h96;
      21'h2014: r.code = 8'h97;
      21'h2018: r.code = 8'h91;
      21'h2019: r.code = 8'h92;
      21'h201A: r.code = 8'h82;
      21'h201C: r.code = 8'h93;
      21'h201D: r.code = 8'h94;
      21'h201E: r.code = 8'h84;
      21'h2020: r.code = 8'h86;
      21'h2021: r.code = 8'h87;
      21'h2022: r.code = 8'h95;
      21'h2026: r.code = 8'h85;
      21'h2030: r.code = 8'h89;
      21'h2039: r.code = 8'h8B;
      21'h203A: r.code = 8'h9B;
      21'h20AC: r.code = 8'h80;
      21'h2122: r.code = 8'h99;
      default:  r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/utf8_to_cp1252_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_cp1252_transcoder_core
// Strict streaming UTF-8 decoder that re-encodes to Latin-1 or Windows-1252.
// ----------------------------------------------------------------------------
// One UTF-8 byte is taken per cycle on the slave stream, tlast marking the last
// byte of a string. Each byte passes an input register, is decoded by one level
// of logic against the sequence state, and any result lands in an output
// register, and one byte is accepted every cycle while
// the master side keeps up. A completed code point up to U+00FF comes out as
// that byte; with allow_high_table set, 27 code points map to 0x80-0x9F. The
// first error of a string yields one result with tlast set (invalid sequence
// with its byte offset, or unrepresentable code point), and the rest of that
// string is dropped up to its tlast byte. Offsets saturate at all ones.
// allow_high_table resets to 1 and may only be written while the block is idle.
module utf8_to_cp1252_transcoder_core #(
  parameter int unsigned OFFSET_BITS = u8cp_pkg::OffsetBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave stream: tdata = {in_byte}, tlast = end_of_string
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [u8cp_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tlast,
  // master stream: tdata from bit 0 up = out_byte[7:0], error_offset[15:0],
  // bad_code_point[20:0], pad[2:0]; tuser = status; tlast = last
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [u8cp_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [u8cp_pkg::StatusW-1:0]   m_axis_tuser,
  output logic                           m_axis_tlast,
  // allow_high_table register
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i
);
  import u8cp_pkg::*;

  localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};

  // input register
  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  logic                 in_end_q;
  logic                 in_fire;

  // result register
  logic                 out_vld_q, out_vld_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic [StatusW-1:0]   out_st_q, out_st_d;
  logic [ErrOffW-1:0]   out_off_q, out_off_d;
  logic [CodeW-1:0]     out_cp_q, out_cp_d;
  logic                 out_last_q, out_last_d;
  logic                 out_ready;

  // sequence state
  logic                 allow_q;
  logic [1:0]           pend_q, pend_d;
  logic [CodeW-1:0]     pc_q, pc_d;
  logic [2:0]           cls_q, cls_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                 drop_q, drop_d;

  // decode
  logic                 res;
  logic                 invalid;
  logic                 complete;
  logic [OFFSET_BITS-1:0] bad_off;
  logic [CodeW-1:0]     cp;
  logic [CodeW-1:0]     pc_next;
  logic [7:0]           lo, hi;
  logic [31:0]          bad_off32;
  map_t                 map;

  assign out_ready     = !out_vld_q || m_axis_tready;
  assign in_fire       = in_vld_q && out_ready;
  assign s_axis_tready = !in_vld_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b1;
    end else if (cfg_we_i) begin
      allow_q <= cfg_wdata_i;
    end
  end

  assign pc_next = {pc_q[CodeW-7:0], in_byte_q[5:0]};
  assign map     = cp1252_lookup(cp);

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    case (cls_q)
      ClsE0:   lo = 8'hA0;
      ClsEd:   hi = 8'h9F;
      ClsF0:   lo = 8'h90;
      ClsF4:   hi = 8'h8F;
      default: ;
    endcase
  end

  always_comb begin
    pend_d   = pend_q;
    pc_d     = pc_q;
    cls_d    = cls_q;
    start_d  = start_q;
    drop_d   = drop_q;
    pos_d    = (pos_q != PosMax) ? pos_q + OFFSET_BITS'(1) : pos_q;
    invalid  = 1'b0;
    complete = 1'b0;
    bad_off  = '0;
    cp       = '0;
    res      = 1'b0;
    out_byte_d = 8'h00;
    out_st_d   = StByte;
    out_cp_d   = '0;
    out_last_d = 1'b0;

    if (!drop_q) begin
      if (pend_q == 2'd0) begin
        start_d = pos_q;
        if (in_byte_q < 8'h80) begin
          cp       = {13'd0, in_byte_q};
          complete = 1'b1;
        end else if (in_byte_q < 8'hC2 || in_byte_q > 8'hF4) begin
          invalid = 1'b1;
          bad_off = pos_q;
        end else if (in_byte_q < 8'hE0) begin
          pend_d = 2'd1;
          pc_d   = {16'd0, in_byte_q[4:0]};
          cls_d  = ClsAny;
        end else if (in_byte_q < 8'hF0) begin
          pend_d = 2'd2;
          pc_d   = {17'd0, in_byte_q[3:0]};
          cls_d  = (in_byte_q == 8'hE0) ? ClsE0 : (in_byte_q == 8'hED) ? ClsEd : ClsAny;
        end else begin
          pend_d = 2'd3;
          pc_d   = {18'd0, in_byte_q[2:0]};
          cls_d  = (in_byte_q == 8'hF0) ? ClsF0 : (in_byte_q == 8'hF4) ? ClsF4 : ClsAny;
        end
      end else if (in_byte_q < lo || in_byte_q > hi) begin
        invalid = 1'b1;
        bad_off = start_q;
      end else begin
        pc_d   = pc_next;
        cls_d  = ClsAny;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          cp       = pc_next;
          complete = 1'b1;
        end
      end

      // truncated sequence: report the lead byte
      if (!invalid && !complete && in_end_q) begin
        invalid = 1'b1;
        bad_off = start_d;
      end

      if (invalid) begin
        res        = 1'b1;
        out_st_d   = StInvalid;
        out_last_d = 1'b1;
        pend_d     = 2'd0;
        pc_d       = '0;
        cls_d      = ClsAny;
        drop_d     = 1'b1;
      end else if (complete) begin
        res  = 1'b1;
        pc_d = '0;
        if (cp <= 21'h0000FF) begin
          out_byte_d = cp[7:0];
          out_last_d = in_end_q;
        end else if (allow_q && map.hit) begin
          out_byte_d = map.code;
          out_last_d = in_end_q;
        end else begin
          out_st_d   = StUnrep;
          out_cp_d   = cp;
          out_last_d = 1'b1;
          drop_d     = 1'b1;
        end
      end
    end

    // end of string clears everything but the register
    if (in_end_q) begin
      pend_d  = 2'd0;
      pc_d    = '0;
      cls_d   = ClsAny;
      pos_d   = '0;
      start_d = '0;
      drop_d  = 1'b0;
    end
  end

  assign bad_off32 = 32'(bad_off);
  assign out_off_d = (|bad_off32[31:16]) ? 16'hFFFF : bad_off32[15:0];
  assign out_vld_d = in_fire ? res : (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 2'd0;
      pc_q    <= '0;
      cls_q   <= ClsAny;
      pos_q   <= '0;
      start_q <= '0;
      drop_q  <= 1'b0;
    end else if (in_fire) begin
      pend_q  <= pend_d;
      pc_q    <= pc_d;
      cls_q   <= cls_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res) begin
      out_byte_q <= out_byte_d;
      out_st_q   <= out_st_d;
      out_off_q  <= out_off_d;
      out_cp_q   <= out_cp_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_cp_q, out_off_q, out_byte_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

  // skipping a string leaves no sequence open
  a_drop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (pend_q == 2'd0 && pc_q == '0))
    else $error("open sequence while dropping");

  // a narrowed continuation range only exists inside a sequence
  a_cls_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_q != ClsAny) |-> (pend_q != 2'd0))
    else $error("continuation class without pending bytes");

  // every error result closes its string
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q != StByte) |-> out_last_q)
    else $error("error result without last");

  // a byte result carries no error detail
  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q == StByte) |-> (out_off_q == '0 && out_cp_q == '0))
    else $error("byte result with error fields set");

  // nothing is lost: a result only leaves the register on a request or a refill
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> out_vld_q)
    else $error("pending result dropped");

endmodule
